// ===== sv/lsf_pkg.sv =====
// Shared types, widths and defaults for the least-squares line fit block.
package lsf_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_POINTS = 256;
    localparam int DEF_FRAC_BITS  = 16;

    // Fixed field widths
    localparam int X_W   = 16;
    localparam int OUT_W = 32;

    // Saturation bounds of a coefficient
    localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

    // Product terms of the fit, issued in pairs: first added, second subtracted
    typedef enum logic [2:0] {
        MUL_N_SXX,
        MUL_SX_SX,
        MUL_N_SXY,
        MUL_SX_SY,
        MUL_SXX_SY,
        MUL_SX_SXY
    } t_mul_op;

    // Destination of a finished product pair
    typedef enum logic [1:0] {
        DST_NONE,
        DST_DET,
        DST_NUM_A,
        DST_NUM_B
    } t_dst;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_GO,
        S_MUL_RUN,
        S_DIV_A_GO,
        S_DIV_A_RUN,
        S_DIV_B_GO,
        S_DIV_B_RUN,
        S_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic    accum;
        logic    clear;
        logic    mul_start;
        t_mul_op op;
        logic    mul_clr;
        logic    mul_sub;
        t_dst    store;
        logic    div_start;
        logic    div_sel;
        logic    slope_store;
        logic    out_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic det_bad;
        logic out_free;
    } t_stat;

endpackage

// ===== sv/least_squares_line_fit.sv =====
// Top level of the least-squares line fit: controller plus datapath.
//
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+------------------------------------------------
//  points   | i_valid  | o_stall  | i_x_value, i_y_value, i_last
//  result   | o_valid  | i_stall  | o_slope, o_intercept, o_degenerate, o_too_many
//
// A point beat is taken every cycle while the block is idle; its sums update in that cycle.
// A beat with i_last starts the fit: six serial multiplies with an SX_W-bit multiplier
// (SX_W = 16 + clog2(MAX_POINTS)), then two restoring divisions of a NUM_W-bit numerator
// (NUM_W = 2*SX_W + 16); a degenerate set skips the divisions. o_stall stays high until
// the result is loaded into the output register, which holds under i_stall. Synchronous
// active-low reset clears all sums.
module least_squares_line_fit
    import lsf_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [X_W-1:0]   i_x_value,
    input  logic signed [X_W-1:0]   i_y_value,
    input  logic                    i_last,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OUT_W-1:0] o_slope,
    output logic signed [OUT_W-1:0] o_intercept,
    output logic                    o_degenerate,
    output logic                    o_too_many
);

    t_cmd  w_cmd;
    t_stat w_stat;

    lsf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_last),
        .o_stall (o_stall),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    lsf_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_x_value    (i_x_value),
        .i_y_value    (i_y_value),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_slope      (o_slope),
        .o_intercept  (o_intercept),
        .o_degenerate (o_degenerate),
        .o_too_many   (o_too_many)
    );

endmodule

// ===== sv/lsf_div.sv =====
// Restoring divider: rounded, scaled and saturated quotient of a signed numerator by det.
module lsf_div
    import lsf_pkg::*;
#(
    parameter int NUM_W     = 64,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic        [NUM_W-1:0] i_det,
    output logic                    o_done,
    output logic        [OUT_W-1:0] o_quot
);

    localparam int DVD_W   = NUM_W + FRAC_BITS + 2;
    localparam int DSTEP_W = $clog2(DVD_W);
    localparam logic [OUT_W:0] LIM_POS = {2'b00, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W:0] LIM_NEG = {2'b01, {(OUT_W-1){1'b0}}};

    logic               r_busy;
    logic               r_done;
    logic [DSTEP_W-1:0] r_step;
    logic [DVD_W-1:0]   r_dvd;
    logic [NUM_W-1:0]   r_rem;
    logic [NUM_W-1:0]   r_dvsr;
    logic [OUT_W:0]     r_q;
    logic               r_qovf;
    logic               r_neg;

    logic [NUM_W-1:0]   w_mag;
    logic [DVD_W-1:0]   w_dvd;
    logic [NUM_W:0]     w_trial;
    logic [NUM_W:0]     w_diff;
    logic               w_ge;
    logic               w_last;
    logic               w_big;

    // Form |num| * 2^(F+1) + det, so the quotient by 2*det rounds half away from zero
    always_comb begin
        w_mag = i_num[NUM_W-1] ? (~i_num + 1'b1) : i_num;
        w_dvd = (DVD_W'(w_mag) << (FRAC_BITS + 1)) + DVD_W'(i_det);
    end

    // One quotient bit per cycle
    always_comb begin
        w_trial = {r_rem, r_dvd[DVD_W-1]};
        w_diff  = w_trial - {1'b0, r_dvsr};
        w_ge    = (w_trial >= {1'b0, r_dvsr});
        w_last  = (r_step == DSTEP_W'(DVD_W - 1));
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= w_dvd;
            r_rem  <= '0;
            r_dvsr <= {i_det[NUM_W-2:0], 1'b0};
            r_q    <= '0;
            r_qovf <= 1'b0;
            r_neg  <= i_num[NUM_W-1];
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem  <= w_ge ? w_diff[NUM_W-1:0] : w_trial[NUM_W-1:0];
            r_q    <= {r_q[OUT_W-1:0], w_ge};
            r_qovf <= r_qovf | r_q[OUT_W];
        end
    end

    // Saturate and apply the sign
    always_comb begin
        w_big = r_qovf || (r_q > (r_neg ? LIM_NEG : LIM_POS));
        if (w_big) begin
            o_quot = r_neg ? SAT_NEG : SAT_POS;
        end else begin
            o_quot = r_neg ? (~r_q[OUT_W-1:0] + 1'b1) : r_q[OUT_W-1:0];
        end
    end

    assign o_done = r_done;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

endmodule

// ===== sv/lsf_datapath.sv =====
// Datapath: point sums, serial multiplier for the fit terms, divider and result register.
module lsf_datapath
    import lsf_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    input  logic signed [X_W-1:0]   i_x_value,
    input  logic signed [X_W-1:0]   i_y_value,
    input  logic                    i_stall,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_slope,
    output logic signed [OUT_W-1:0] o_intercept,
    output logic                    o_degenerate,
    output logic                    o_too_many
);

    localparam int LOG_N   = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int SX_W    = X_W + LOG_N;
    localparam int SXX_W   = 2 * X_W + LOG_N;
    localparam int NUM_W   = SX_W + SXX_W;
    localparam int MSTEP_W = $clog2(SX_W);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_POINTS);

    // Point sums
    logic        [CNT_W-1:0] r_cnt;
    logic signed [SX_W-1:0]  r_sx;
    logic signed [SX_W-1:0]  r_sy;
    logic signed [SXX_W-1:0] r_sxx;
    logic signed [SXX_W-1:0] r_sxy;
    logic                    r_ovf;
    logic signed [2*X_W-1:0] w_xx;
    logic signed [2*X_W-1:0] w_xy;
    logic                    w_full;

    // Serial multiplier
    logic                    r_mbusy;
    logic                    r_mdone;
    logic [MSTEP_W-1:0]      r_mstep;
    logic signed [NUM_W-1:0] r_mcand;
    logic [SX_W-1:0]         r_mplier;
    logic                    r_msub;
    logic signed [NUM_W-1:0] r_acc;
    logic signed [NUM_W-1:0] w_mul_a;
    logic [SX_W-1:0]         w_mul_b;
    logic signed [NUM_W-1:0] w_term;
    logic                    w_mlast;

    // Fit terms and results
    logic signed [NUM_W-1:0] r_det;
    logic signed [NUM_W-1:0] r_num_a;
    logic signed [NUM_W-1:0] r_num_b;
    logic        [OUT_W-1:0] r_slope_w;
    logic                    w_det_bad;
    logic                    w_div_done;
    logic        [OUT_W-1:0] w_div_quot;
    logic signed [NUM_W-1:0] w_div_num;

    logic                    r_out_valid;
    logic        [OUT_W-1:0] r_o_slope;
    logic        [OUT_W-1:0] r_o_intercept;
    logic                    r_o_degenerate;
    logic                    r_o_too_many;

    // Point products
    always_comb begin
        w_xx   = i_x_value * i_x_value;
        w_xy   = i_x_value * i_y_value;
        w_full = (r_cnt == CAP);
    end

    // Accumulate a beat, drop it when full, clear after the fit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxx <= '0;
            r_sxy <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.clear) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxx <= '0;
            r_sxy <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.accum) begin
            if (w_full) begin
                r_ovf <= 1'b1;
            end else begin
                r_cnt <= r_cnt + 1'b1;
                r_sx  <= r_sx + SX_W'(i_x_value);
                r_sy  <= r_sy + SX_W'(i_y_value);
                r_sxx <= r_sxx + SXX_W'(w_xx);
                r_sxy <= r_sxy + SXX_W'(w_xy);
            end
        end
    end

    // Select the operands of a product term
    always_comb begin
        case (i_cmd.op)
            MUL_N_SXX: begin
                w_mul_a = NUM_W'(r_sxx);
                w_mul_b = {{(SX_W-CNT_W){1'b0}}, r_cnt};
            end
            MUL_SX_SX: begin
                w_mul_a = NUM_W'(r_sx);
                w_mul_b = r_sx;
            end
            MUL_N_SXY: begin
                w_mul_a = NUM_W'(r_sxy);
                w_mul_b = {{(SX_W-CNT_W){1'b0}}, r_cnt};
            end
            MUL_SX_SY: begin
                w_mul_a = NUM_W'(r_sx);
                w_mul_b = r_sy;
            end
            MUL_SXX_SY: begin
                w_mul_a = NUM_W'(r_sxx);
                w_mul_b = r_sy;
            end
            MUL_SX_SXY: begin
                w_mul_a = NUM_W'(r_sxy);
                w_mul_b = r_sx;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Shift-add step; the sign bit of the multiplier weighs negative
    always_comb begin
        w_mlast = (r_mstep == MSTEP_W'(SX_W - 1));
        w_term  = r_mplier[0] ? r_mcand : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
            r_mstep <= '0;
        end else begin
            r_mdone <= r_mbusy && w_mlast;
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
                r_mstep <= '0;
            end else if (r_mbusy) begin
                r_mstep <= r_mstep + 1'b1;
                if (w_mlast) begin
                    r_mbusy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_mcand  <= w_mul_a;
            r_mplier <= w_mul_b;
            r_msub   <= i_cmd.mul_sub;
            if (i_cmd.mul_clr) begin
                r_acc <= '0;
            end
        end else if (r_mbusy) begin
            r_mcand  <= r_mcand <<< 1;
            r_mplier <= r_mplier >> 1;
            r_acc    <= (w_mlast ^ r_msub) ? (r_acc - w_term) : (r_acc + w_term);
        end
    end

    // Hold finished terms
    always_ff @(posedge i_clk) begin
        case (i_cmd.store)
            DST_DET:   r_det   <= r_acc;
            DST_NUM_A: r_num_a <= r_acc;
            DST_NUM_B: r_num_b <= r_acc;
            default:   ;
        endcase
        if (i_cmd.slope_store) begin
            r_slope_w <= w_div_quot;
        end
    end

    assign w_det_bad = (r_det == '0) || r_det[NUM_W-1];
    assign w_div_num = i_cmd.div_sel ? r_num_b : r_num_a;

    lsf_div #(
        .NUM_W     (NUM_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_div_num),
        .i_det   (r_det),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // Result register: load one beat, release it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_slope      <= w_det_bad ? '0 : r_slope_w;
            r_o_intercept  <= w_det_bad ? '0 : w_div_quot;
            r_o_degenerate <= w_det_bad;
            r_o_too_many   <= r_ovf;
        end
    end

    always_comb begin
        o_stat.mul_done = r_mdone;
        o_stat.div_done = w_div_done;
        o_stat.det_bad  = w_det_bad;
        o_stat.out_free = !r_out_valid || !i_stall;
    end

    assign o_valid      = r_out_valid;
    assign o_slope      = r_o_slope;
    assign o_intercept  = r_o_intercept;
    assign o_degenerate = r_o_degenerate;
    assign o_too_many   = r_o_too_many;

    a_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_start |-> !r_mbusy)
        else $error("multiplier restarted while busy");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_stall))
        else $error("result overwritten while stalled");

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP)
        else $error("point count beyond capacity");

endmodule

// ===== sv/lsf_ctrl.sv =====
// Controller: accepts points, sequences the fit terms, divisions and result load.
module lsf_ctrl
    import lsf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_last,
    output logic  o_stall,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    t_state  r_state;
    t_state  n_state;
    t_mul_op r_op;
    t_mul_op n_op;
    logic    w_accept;
    logic    w_first;

    assign w_accept = i_valid && (r_state == S_IDLE);

    // A pair opens with its added term, which also clears the accumulator
    assign w_first = (r_op == MUL_N_SXX) || (r_op == MUL_N_SXY) || (r_op == MUL_SXX_SY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= MUL_N_SXX;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // Advance the product term after each finished multiply
    always_comb begin
        n_op = r_op;
        if ((r_state == S_MUL_RUN) && i_stat.mul_done) begin
            case (r_op)
                MUL_N_SXX:  n_op = MUL_SX_SX;
                MUL_SX_SX:  n_op = MUL_N_SXY;
                MUL_N_SXY:  n_op = MUL_SX_SY;
                MUL_SX_SY:  n_op = MUL_SXX_SY;
                MUL_SXX_SY: n_op = MUL_SX_SXY;
                default:    n_op = MUL_N_SXX;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_last) begin
                    n_state = S_MUL_GO;
                end
            end
            S_MUL_GO: begin
                n_state = S_MUL_RUN;
            end
            S_MUL_RUN: begin
                if (i_stat.mul_done) begin
                    if (r_op == MUL_SX_SXY) begin
                        n_state = i_stat.det_bad ? S_OUT : S_DIV_A_GO;
                    end else begin
                        n_state = S_MUL_GO;
                    end
                end
            end
            S_DIV_A_GO: begin
                n_state = S_DIV_A_RUN;
            end
            S_DIV_A_RUN: begin
                if (i_stat.div_done) begin
                    n_state = S_DIV_B_GO;
                end
            end
            S_DIV_B_GO: begin
                n_state = S_DIV_B_RUN;
            end
            S_DIV_B_RUN: begin
                if (i_stat.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = r_op;
        o_cmd.store   = DST_NONE;
        o_cmd.mul_clr = w_first;
        o_cmd.mul_sub = !w_first;
        o_stall       = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall     = 1'b0;
                o_cmd.accum = w_accept;
            end
            S_MUL_GO: begin
                o_cmd.mul_start = 1'b1;
            end
            S_MUL_RUN: begin
                if (i_stat.mul_done) begin
                    case (r_op)
                        MUL_SX_SX:  o_cmd.store = DST_DET;
                        MUL_SX_SY:  o_cmd.store = DST_NUM_A;
                        MUL_SX_SXY: o_cmd.store = DST_NUM_B;
                        default:    o_cmd.store = DST_NONE;
                    endcase
                end
            end
            S_DIV_A_GO: begin
                o_cmd.div_start = 1'b1;
            end
            S_DIV_A_RUN: begin
                o_cmd.slope_store = i_stat.div_done;
            end
            S_DIV_B_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = 1'b1;
            end
            S_DIV_B_RUN: begin
                o_cmd.div_sel = 1'b1;
            end
            S_OUT: begin
                o_cmd.div_sel  = 1'b1;
                o_cmd.out_load = i_stat.out_free;
                o_cmd.clear    = i_stat.out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    a_mul_done_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.mul_done |-> (r_state == S_MUL_RUN))
        else $error("multiply finished outside its wait state");

    a_accum_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accum && i_last) |=> (r_state == S_MUL_GO))
        else $error("last beat did not start the fit");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the least-squares line fit: point sets in, fit results checked.
`timescale 1ns / 1ps

module tb_top
    import lsf_pkg::*;
();

    localparam int MAX_PTS     = DEF_MAX_POINTS;
    localparam int FRAC        = DEF_FRAC_BITS;
    localparam int ITEMS       = 1100;
    localparam int TAIL_ITEMS  = 120;
    localparam int HOLD_CYCLES = 2500;
    localparam int HOLD_AT_PTS = 300;
    localparam int DRAIN_WAIT  = 400;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic                  last;
    } t_point;

    typedef struct {
        logic signed [OUT_W-1:0] slope;
        logic signed [OUT_W-1:0] icpt;
        logic                    degen;
        logic                    capped;
    } t_fit;

    typedef enum int {
        SET_LINE,
        SET_NOISE,
        SET_FLAT_X,
        SET_STEEP
    } t_set_kind;

    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    i_valid     = 1'b0;
    logic signed [X_W-1:0]   i_x_value   = '0;
    logic signed [X_W-1:0]   i_y_value   = '0;
    logic                    i_last      = 1'b0;
    logic                    i_stall     = 1'b0;
    logic                    o_stall;
    logic                    o_valid;
    logic signed [OUT_W-1:0] o_slope;
    logic signed [OUT_W-1:0] o_intercept;
    logic                    o_degenerate;
    logic                    o_too_many;

    t_point pending[$];
    t_fit   fits_due[$];

    // Running sums of the set being collected
    int     pt_count;
    longint acc_x, acc_y, acc_xx, acc_xy;
    logic   pt_dropped;

    int     errors     = 0;
    int     pts_taken  = 0;
    int     fits_seen  = 0;
    int     degen_seen = 0;
    int     sat_seen   = 0;
    int     cap_seen   = 0;
    int     items_made = 0;
    int     gap_left   = 0;
    int     stall_left = 0;
    int     cycle_cnt  = 0;
    logic   quiet      = 1'b0;
    logic   hold_off   = 1'b0;

    least_squares_line_fit #(
        .MAX_POINTS(MAX_PTS),
        .FRAC_BITS (FRAC)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_x_value   (i_x_value),
        .i_y_value   (i_y_value),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_slope     (o_slope),
        .o_intercept (o_intercept),
        .o_degenerate(o_degenerate),
        .o_too_many  (o_too_many)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
        errors++;
    endtask

    function automatic int clamp16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Scale num/det by 2^FRAC, round half away from zero, saturate to 32 bits
    function automatic logic [OUT_W-1:0] scaled_quotient(input logic signed [127:0] num,
                                                         input logic [127:0] det);
        logic           neg;
        logic [127:0]   mag;
        logic [191:0]   scaled;
        logic [191:0]   quo;
        logic [OUT_W-1:0] lim;
        logic [OUT_W-1:0] r;
        neg    = num[127];
        mag    = neg ? -num : num;
        scaled = ({64'b0, mag} << (FRAC + 1)) + {64'b0, det};
        quo    = scaled / ({64'b0, det} << 1);
        lim    = neg ? SAT_NEG : SAT_POS;
        r      = (quo > {160'b0, lim}) ? lim : quo[OUT_W-1:0];
        if (neg) r = -r;
        return r;
    endfunction

    // Fold one accepted point into the sums; on the last point, queue the fit
    task automatic fold_point(input logic signed [X_W-1:0] x, input logic signed [X_W-1:0] y,
                              input logic last);
        logic signed [127:0] n_w, sx, sy, sxx, sxy, det, num_a, num_b;
        t_fit f;
        if (pt_count < MAX_PTS) begin
            acc_x  += longint'(x);
            acc_y  += longint'(y);
            acc_xx += longint'(x) * longint'(x);
            acc_xy += longint'(x) * longint'(y);
            pt_count++;
        end else begin
            pt_dropped = 1'b1;
        end
        if (last) begin
            n_w = 128'(pt_count);
            sx  = 128'(acc_x);
            sy  = 128'(acc_y);
            sxx = 128'(acc_xx);
            sxy = 128'(acc_xy);
            det = n_w * sxx - sx * sx;
            if (det <= 0) begin
                f.slope = '0;
                f.icpt  = '0;
                f.degen = 1'b1;
            end else begin
                num_a   = n_w * sxy - sx * sy;
                num_b   = sxx * sy - sx * sxy;
                f.slope = scaled_quotient(num_a, det);
                f.icpt  = scaled_quotient(num_b, det);
                f.degen = 1'b0;
            end
            f.capped = pt_dropped;
            fits_due.push_back(f);
            pt_count   = 0;
            acc_x      = 0;
            acc_y      = 0;
            acc_xx     = 0;
            acc_xy     = 0;
            pt_dropped = 1'b0;
        end
    endtask

    function automatic void add_point(input int x, input int y, input bit last);
        t_point p;
        p.x    = x[X_W-1:0];
        p.y    = y[X_W-1:0];
        p.last = last;
        pending.push_back(p);
        items_made++;
    endfunction

    // Build one point set of the given shape; the final point carries last
    task automatic queue_set(input t_set_kind kind, input int size);
        int gain, shift, offs, base, span, xv, yv, k;
        gain  = int'($urandom_range(0, 64)) - 32;
        shift = $urandom_range(0, 4);
        offs  = int'($urandom_range(0, 65535)) - 32768;
        base  = int'($urandom_range(0, 65535)) - 32768;
        span  = 1 << $urandom_range(0, 15);
        for (k = 0; k < size; k++) begin
            xv = clamp16(base + int'($urandom_range(0, span)) - span / 2);
            case (kind)
                SET_LINE: begin
                    yv = clamp16(((gain * xv) >>> shift) + offs + int'($urandom_range(0, 8)) - 4);
                end
                SET_NOISE: begin
                    xv = int'($urandom_range(0, 65535)) - 32768;
                    yv = int'($urandom_range(0, 65535)) - 32768;
                end
                SET_FLAT_X: begin
                    xv = base;
                    yv = int'($urandom_range(0, 65535)) - 32768;
                end
                default: begin
                    xv = clamp16(base + int'($urandom_range(0, 1)));
                    yv = int'($urandom_range(0, 65535)) - 32768;
                end
            endcase
            add_point(xv, yv, k == size - 1);
        end
    endtask

    // Driver: offer pending points, fold accepted beats into the prediction
    always @(posedge i_clk) begin : drive_points
        t_point nxt;
        logic   v_next;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            v_next = i_valid;
            if (i_valid && !o_stall) begin
                fold_point(i_x_value, i_y_value, i_last);
                pts_taken++;
                v_next = 1'b0;
                if (!quiet && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 16);
            end
            if (!v_next) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending.size() > 0) begin
                    nxt = pending.pop_front();
                    i_x_value <= nxt.x;
                    i_y_value <= nxt.y;
                    i_last    <= nxt.last;
                    v_next    = 1'b1;
                end
            end
            i_valid <= v_next;
            quiet   <= (pending.size() < TAIL_ITEMS);
        end
    end

    // Monitor: check each result beat against the oldest predicted fit, drive stall
    always @(posedge i_clk) begin : watch_results
        t_fit want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid === 1'b1 && !i_stall) begin
                if (fits_due.size() == 0) begin
                    report_mismatch("result beat with no fit pending");
                end else begin
                    want = fits_due.pop_front();
                    fits_seen++;
                    if (want.degen) degen_seen++;
                    if (want.capped) cap_seen++;
                    if (want.slope == SAT_POS || want.slope == SAT_NEG ||
                        want.icpt == SAT_POS || want.icpt == SAT_NEG) sat_seen++;
                    if (o_slope !== want.slope)
                        report_mismatch($sformatf("slope got %0d want %0d",
                                                  o_slope, want.slope));
                    if (o_intercept !== want.icpt)
                        report_mismatch($sformatf("intercept got %0d want %0d",
                                                  o_intercept, want.icpt));
                    if (o_degenerate !== want.degen)
                        report_mismatch($sformatf("degenerate got %b want %b",
                                                  o_degenerate, want.degen));
                    if (o_too_many !== want.capped)
                        report_mismatch($sformatf("too_many got %b want %b",
                                                  o_too_many, want.capped));
                end
            end
            if (stall_left > 0) stall_left--;
            else if (!quiet && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 16);
            i_stall <= hold_off || (stall_left > 0);
        end
    end

    // Hold off the result side for a long stretch so the block backs up its input
    initial begin : long_hold
        wait (pts_taken >= HOLD_AT_PTS);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("watchdog expired with %0d fits outstanding", fits_due.size());
            $display("least_squares_line_fit test failed");
            $finish;
        end
    end

    initial begin : run_test
        int set_no;
        int size;
        pt_count   = 0;
        acc_x      = 0;
        acc_y      = 0;
        acc_xx     = 0;
        acc_xy     = 0;
        pt_dropped = 1'b0;

        // Single point: too few for a line
        add_point(-32768, 32767, 1);
        // All x equal
        add_point(5, 1, 0);
        add_point(5, -3, 0);
        add_point(5, 7, 1);
        // Steepest rise, slope saturates high
        add_point(0, -32768, 0);
        add_point(1, 32767, 1);
        // Steepest fall, slope saturates low
        add_point(0, 32767, 0);
        add_point(1, -32768, 1);
        // Intercept saturates at the far end of x
        add_point(32766, -32768, 0);
        add_point(32767, 32767, 1);
        // Field extremes
        add_point(-32768, -32768, 0);
        add_point(32767, 32767, 0);
        add_point(0, 0, 1);
        // Exact line y = 2x + 3
        add_point(1, 5, 0);
        add_point(2, 7, 0);
        add_point(3, 9, 0);
        add_point(4, 11, 1);
        // Negative values, inexact fit
        add_point(-100, 50, 0);
        add_point(-200, 300, 0);
        add_point(-300, -20, 1);

        // Random sets, mostly short; one exactly at capacity and one past it
        set_no = 0;
        while (items_made < ITEMS) begin
            if (set_no == 12) begin
                queue_set(SET_LINE, MAX_PTS);
            end else if (set_no == 40) begin
                queue_set(SET_NOISE, MAX_PTS + 6);
            end else begin
                size = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9: queue_set(SET_LINE, size);
                    10, 11, 12, 13, 14:           queue_set(SET_NOISE, size);
                    15, 16:                       queue_set(SET_FLAT_X, size);
                    default:                      queue_set(SET_STEEP, size);
                endcase
            end
            set_no++;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all points taken and every predicted fit seen
        do @(posedge i_clk);
        while (pending.size() > 0 || i_valid || fits_due.size() > 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d points in %0d fitted sets", pts_taken, fits_seen);
        $display("  %0d degenerate, %0d saturated, %0d over capacity, %0d mismatches",
                 degen_seen, sat_seen, cap_seen, errors);
        if (errors == 0) begin
            $display("least_squares_line_fit test passed");
        end else begin
            $display("least_squares_line_fit test failed");
        end
        $finish;
    end

endmodule
